### hw/rtl/tbl_pkg.sv
package tbl_pkg;

   // Field widths of the tape block loader.
   localparam int ByteWidth = 8;
   localparam int AddrWidth = 16;
   localparam int CountWidth = 16;
   localparam int StatusWidth = 3;

   // Configuration port geometry.
   localparam int CsrDataWidth = 32;
   localparam int CsrAddrWidth = 4;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      REG_EXPECTED_TYPE = 2'd0,
      REG_DATA_COUNT    = 2'd1,
      REG_START_ADDRESS = 2'd2,
      REG_VERIFY_MODE   = 2'd3
   } reg_index_type;

   // Outcome codes reported with every result.
   typedef enum logic [StatusWidth-1:0] {
      STATUS_BUSY     = 3'd0,
      STATUS_OK       = 3'd1,
      STATUS_WRONG    = 3'd2,
      STATUS_MISMATCH = 3'd3,
      STATUS_TRUNC    = 3'd4,
      STATUS_CRC_ONE  = 3'd5,
      STATUS_CRC_BAD  = 3'd6,
      STATUS_IGNORED  = 3'd7
   } status_type;

   // Where the block stands within the current tape block.
   typedef enum logic [1:0] {
      PHASE_TYPE   = 2'd0,
      PHASE_BODY   = 2'd1,
      PHASE_IGNORE = 2'd2
   } phase_type;

   // Configuration handed from the register bank to the datapath.
   typedef struct packed {
      logic [ByteWidth-1:0]  expected_type;
      logic [CountWidth-1:0] data_count;
      logic [AddrWidth-1:0]  start_address;
      logic                  verify_mode;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic                  write_enable;
      logic [AddrWidth-1:0]  write_address;
      logic [ByteWidth-1:0]  write_data;
      status_type            status;
      logic [CountWidth-1:0] bytes_done;
      logic [ByteWidth-1:0]  report_byte;
      logic [ByteWidth-1:0]  checksum_residue;
   } rsp_payload_type;

endpackage

### hw/rtl/tbl_if.sv
// Request channel: one tape byte with its memory byte and end marker.
interface tbl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] tape_byte;
   logic [7:0] memory_byte;
   logic       block_end;

   modport source (output valid, output tape_byte, output memory_byte,
                   output block_end, input ready);
   modport sink (input valid, input tape_byte, input memory_byte,
                 input block_end, output ready);
endinterface

// Result channel: the outcome of one request.
interface tbl_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_enable;
   logic [15:0] write_address;
   logic [7:0]  write_data;
   logic [2:0]  status;
   logic [15:0] bytes_done;
   logic [7:0]  report_byte;
   logic [7:0]  checksum_residue;

   modport source (output valid, output write_enable, output write_address,
                   output write_data, output status, output bytes_done,
                   output report_byte, output checksum_residue, input ready);
   modport sink (input valid, input write_enable, input write_address,
                 input write_data, input status, input bytes_done,
                 input report_byte, input checksum_residue, output ready);
endinterface

### hw/rtl/tbl_csr.sv
module tbl_csr
   import tbl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_strobe;

   assign pready = 1'b1;
   assign index = reg_index_type'(paddr[CsrAddrWidth-1:2]);
   assign write_strobe = psel && penable && pwrite;

   // Register writes at the access cycle.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         unique case (index)
            REG_EXPECTED_TYPE: cfg_in.expected_type = pwdata[ByteWidth-1:0];
            REG_DATA_COUNT:    cfg_in.data_count = pwdata[CountWidth-1:0];
            REG_START_ADDRESS: cfg_in.start_address = pwdata[AddrWidth-1:0];
            REG_VERIFY_MODE:   cfg_in.verify_mode = pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back of the addressed register.
   always_comb begin
      prdata = '0;
      unique case (index)
         REG_EXPECTED_TYPE: prdata[ByteWidth-1:0] = cfg_ff.expected_type;
         REG_DATA_COUNT:    prdata[CountWidth-1:0] = cfg_ff.data_count;
         REG_START_ADDRESS: prdata[AddrWidth-1:0] = cfg_ff.start_address;
         REG_VERIFY_MODE:   prdata[0] = cfg_ff.verify_mode;
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/tbl_core.sv
module tbl_core
   import tbl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   tbl_req_if.sink   req,
   tbl_rsp_if.source rsp
);

   // Input register.
   logic                 in_valid_ff;
   logic [ByteWidth-1:0] tape_ff;
   logic [ByteWidth-1:0] mem_ff;
   logic                 end_ff;

   // Block state.
   phase_type             phase_ff;
   phase_type             phase_in;
   logic [CountWidth-1:0] offset_ff;
   logic [CountWidth-1:0] offset_in;
   logic [ByteWidth-1:0]  xor_ff;
   logic [ByteWidth-1:0]  xor_in;

   // Result register.
   logic            out_valid_ff;
   rsp_payload_type out_ff;
   rsp_payload_type result;

   logic                  advance;
   logic                  take_req;
   logic [ByteWidth-1:0]  residue;
   logic [CountWidth-1:0] offset_next;

   // The input stage moves on whenever the result register is free or being emptied.
   assign advance = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign take_req = req.valid && req.ready;

   assign residue = xor_ff ^ tape_ff;
   assign offset_next = offset_ff + CountWidth'(1);

   // Per-byte decision on the registered request.
   always_comb begin
      result = '0;
      result.status = STATUS_BUSY;
      phase_in = phase_ff;
      offset_in = offset_ff;
      xor_in = xor_ff;
      unique case (phase_ff)
         PHASE_TYPE: begin
            if (tape_ff != cfg.expected_type) begin
               result.status = STATUS_WRONG;
               result.report_byte = tape_ff;
               result.checksum_residue = tape_ff ^ cfg.expected_type;
               phase_in = end_ff ? PHASE_TYPE : PHASE_IGNORE;
            end else begin
               xor_in = tape_ff;
               offset_in = '0;
               if (end_ff) begin
                  result.status = STATUS_TRUNC;
                  phase_in = PHASE_TYPE;
               end else begin
                  phase_in = PHASE_BODY;
               end
            end
         end
         PHASE_BODY: begin
            priority if (offset_ff >= cfg.data_count) begin
               // Checksum byte closes the block.
               if (residue == '0) begin
                  result.status = STATUS_OK;
               end else if (residue == ByteWidth'(1)) begin
                  result.status = STATUS_CRC_ONE;
               end else begin
                  result.status = STATUS_CRC_BAD;
               end
               result.report_byte = tape_ff;
               result.checksum_residue = residue;
               result.bytes_done = offset_ff;
               phase_in = end_ff ? PHASE_TYPE : PHASE_IGNORE;
            end else if (cfg.verify_mode && (tape_ff != mem_ff)) begin
               result.status = STATUS_MISMATCH;
               result.bytes_done = offset_ff;
               phase_in = end_ff ? PHASE_TYPE : PHASE_IGNORE;
            end else begin
               // Data byte: write or verified match.
               result.write_address = cfg.start_address + offset_ff;
               if (!cfg.verify_mode) begin
                  result.write_enable = 1'b1;
                  result.write_data = tape_ff;
               end
               xor_in = residue;
               offset_in = offset_next;
               result.bytes_done = offset_next;
               if (end_ff) begin
                  result.status = STATUS_TRUNC;
                  phase_in = PHASE_TYPE;
               end
            end
         end
         default: begin
            result.status = STATUS_IGNORED;
            phase_in = end_ff ? PHASE_TYPE : PHASE_IGNORE;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff <= PHASE_TYPE;
         offset_ff <= '0;
         xor_ff <= '0;
      end else begin
         if (take_req) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            phase_ff <= phase_in;
            offset_ff <= offset_in;
            xor_ff <= xor_in;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take_req) begin
         tape_ff <= req.tape_byte;
         mem_ff <= req.memory_byte;
         end_ff <= req.block_end;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.write_enable = out_ff.write_enable;
   assign rsp.write_address = out_ff.write_address;
   assign rsp.write_data = out_ff.write_data;
   assign rsp.status = out_ff.status;
   assign rsp.bytes_done = out_ff.bytes_done;
   assign rsp.report_byte = out_ff.report_byte;
   assign rsp.checksum_residue = out_ff.checksum_residue;

endmodule

### hw/rtl/tape_block_load_verify.sv
// Channel    Direction  Carries
// req_chan   in         tape_byte, memory_byte, block_end
// rsp_chan   out        write_enable, write_address, write_data, status,
//                       bytes_done, report_byte, checksum_residue
// psel..     in/out     APB-style register port, four registers
//
// Each request is registered, decided by one pass of compare, XOR and a
// 16-bit count update, and its result registered: one request per cycle
// sustained while rsp_chan is ready, set by the block state register update.
// Reset is synchronous and returns the block to waiting for a type byte.
// A stall on the result channel holds the result register and then the input
// register; a new request is still taken while a finished result waits.
module tape_block_load_verify
   import tbl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   tbl_req_if.sink                 req_chan,
   tbl_rsp_if.source               rsp_chan,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   cfg_type cfg;

   tbl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tbl_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule
